// ===== rtl/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants of the matrix vector mixing block.
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int DEF_MAX_ELECTRODES = 32;
  localparam int DEF_MAX_CHANNELS   = 64;

  localparam int SAMPLE_W  = 16;
  localparam int WEIGHT_W  = 16;
  localparam int PROD_W    = 32;
  localparam int SUM_W     = 40;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 6;
  localparam int POS_W     = 5;
  localparam int ECOUNT_W  = 6;
  localparam int CCOUNT_W  = 7;
  localparam int INDEX_W   = 6;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_DATA_W = 7;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef enum logic {
    REG_ELECTRODE_COUNT = 1'b0,
    REG_CHANNEL_COUNT   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                       start;
    logic                       first;
    logic signed [SAMPLE_W-1:0] sample;
  } mac_cmd_t;

endpackage

// ===== rtl/mvm_ram.sv =====
// ----------------------------------------------------------------------------
// mvm_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/mvm_mac.sv =====
// ----------------------------------------------------------------------------
// mvm_mac
// Sweeps all channel accumulators for one sample: reads a weight and an
// accumulator, multiplies, then adds and writes the sum back.
// ----------------------------------------------------------------------------
module mvm_mac import mvm_pkg::*; #(
  parameter int MAX_ELECTRODES = DEF_MAX_ELECTRODES,
  parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS,
  parameter int EW  = (MAX_ELECTRODES > 1) ? $clog2(MAX_ELECTRODES) : 1,
  parameter int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int WAW = EW + CW
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_cmd_t                cmd,
  input  logic [EW-1:0]           pos_idx,
  output logic                    w_rd_en,
  output logic [WAW-1:0]          w_rd_addr,
  input  logic [WEIGHT_W-1:0]     w_rd_data,
  output logic                    a_rd_en,
  output logic [CW-1:0]           a_rd_addr,
  input  logic [SUM_W-1:0]        a_rd_data,
  output logic                    a_wr_en,
  output logic [CW-1:0]           a_wr_addr,
  output logic [SUM_W-1:0]        a_wr_data,
  output logic                    done
);

  localparam logic [CW-1:0] LAST_CH = CW'(MAX_CHANNELS - 1);

  logic                       run;
  logic [CW-1:0]              cnt;
  logic                       v1;
  logic                       v2;
  logic [CW-1:0]              a1;
  logic [CW-1:0]              a2;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       first;
  logic [EW-1:0]              pos;
  logic signed [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]           accq;
  logic [SUM_W-1:0]           prod_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
    end else begin
      v1 <= run;
      v2 <= v1;
      if (cmd.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        if (cnt == LAST_CH) begin
          run <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sample <= cmd.sample;
      first  <= cmd.first;
      pos    <= pos_idx;
    end
    a1   <= cnt;
    a2   <= a1;
    prod <= sample * $signed(w_rd_data);
    accq <= a_rd_data;
  end

  assign w_rd_en   = run;
  assign w_rd_addr = WAW'({pos, cnt});
  assign a_rd_en   = run;
  assign a_rd_addr = cnt;

  assign prod_ext  = {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign a_wr_en   = v2;
  assign a_wr_addr = a2;
  assign a_wr_data = first ? prod_ext : accq + prod_ext;
  assign done      = v2 && (a2 == LAST_CH);

endmodule

// ===== rtl/mvm_emit.sv =====
// ----------------------------------------------------------------------------
// mvm_emit
// Reads the finished channel sums one by one and presents them as output
// items with a last mark on the final channel.
// ----------------------------------------------------------------------------
module mvm_emit import mvm_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int NCW = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NCW-1:0]        nc,
  output logic                  a_rd_en,
  output logic [CW-1:0]         a_rd_addr,
  input  logic [SUM_W-1:0]      a_rd_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_W-1:0]    out_index,
  output logic [SUM_W-1:0]      out_sum,
  output logic                  out_last,
  output logic                  done
);

  logic [NCW-1:0] count;
  logic [CW-1:0]  cnt;
  logic           rd_pend;
  logic           take;

  assign take      = out_valid && out_ready;
  assign a_rd_en   = start || (take && !out_last);
  assign a_rd_addr = start ? '0 : cnt + 1'b1;
  assign done      = take && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (start) begin
        cnt     <= '0;
        rd_pend <= 1'b1;
      end else if (rd_pend) begin
        rd_pend   <= 1'b0;
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
        if (!out_last) begin
          cnt     <= cnt + 1'b1;
          rd_pend <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count <= nc;
    end
    if (rd_pend) begin
      out_sum   <= a_rd_data;
      out_index <= INDEX_W'(cnt);
      out_last  <= (NCW'(cnt) == count - NCW'(1));
    end
  end

endmodule

// ===== rtl/matrix_vector_mix.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_mix
// A weight load item is written as it is accepted; the input stays ready.
// A sample item sweeps every channel accumulator through one shared
// multiplier, one channel per cycle, and no further item is accepted until
// that sweep over the accumulator memory is done. After the last electrode
// of a vector the sums are read back and sent one at a time, each read only
// once the one before is taken; no input is accepted until the last sum is
// taken. Weights and sums live in memories that need no clearing; the sum
// out of a weight that was never loaded is undefined.
// ----------------------------------------------------------------------------
module matrix_vector_mix import mvm_pkg::*; #(
  parameter int MAX_ELECTRODES = DEF_MAX_ELECTRODES,
  parameter int MAX_CHANNELS   = DEF_MAX_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // weight_row, weight_column, weight_value, sample_value
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // channel_index, channel_sum
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int EW     = (MAX_ELECTRODES > 1) ? $clog2(MAX_ELECTRODES) : 1;
  localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCW    = $clog2(MAX_CHANNELS + 1);
  localparam int WDEPTH = MAX_ELECTRODES * (2 ** CW);
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_EMIT
  } state_t;

  state_t                     state;
  logic [ECOUNT_W-1:0]        electrode_count;
  logic [CCOUNT_W-1:0]        channel_count;
  logic [POS_W-1:0]           position;
  logic                       final_pending;

  logic [ROW_W-1:0]           weight_row;
  logic [COL_W-1:0]           weight_column;
  logic [WEIGHT_W-1:0]        weight_value;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       in_take;
  logic                       is_final;
  logic [6:0]                 ne;
  logic [8:0]                 nc_full;
  logic [NCW-1:0]             nc;
  logic [6:0]                 pos_c;
  logic [EW-1:0]              pos_idx;

  mac_cmd_t                   cmd;
  logic                       w_wr_en;
  logic [WAW-1:0]             w_wr_addr;
  logic                       w_rd_en;
  logic [WAW-1:0]             w_rd_addr;
  logic [WEIGHT_W-1:0]        w_rd_data;
  logic                       mac_a_rd_en;
  logic [CW-1:0]              mac_a_rd_addr;
  logic                       a_wr_en;
  logic [CW-1:0]              a_wr_addr;
  logic [SUM_W-1:0]           a_wr_data;
  logic [SUM_W-1:0]           a_rd_data;
  logic                       mac_done;
  logic                       emit_start;
  logic                       emit_a_rd_en;
  logic [CW-1:0]              emit_a_rd_addr;
  logic                       emit_done;
  logic [INDEX_W-1:0]         out_index;
  logic [SUM_W-1:0]           out_sum;

  assign weight_row    = s_tdata[4:0];
  assign weight_column = s_tdata[10:5];
  assign weight_value  = s_tdata[26:11];
  assign sample_value  = s_tdata[42:27];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = s_tvalid && s_tready;

  always_comb begin
    if (electrode_count == '0) begin
      ne = 7'd1;
    end else if ({1'b0, electrode_count} > 7'(MAX_ELECTRODES)) begin
      ne = 7'(MAX_ELECTRODES);
    end else begin
      ne = {1'b0, electrode_count};
    end
    if (channel_count == '0) begin
      nc_full = 9'd1;
    end else if ({2'b0, channel_count} > 9'(MAX_CHANNELS)) begin
      nc_full = 9'(MAX_CHANNELS);
    end else begin
      nc_full = {2'b0, channel_count};
    end
    if ({2'b0, position} >= 7'(MAX_ELECTRODES)) begin
      pos_c = 7'(MAX_ELECTRODES - 1);
    end else begin
      pos_c = {2'b0, position};
    end
  end

  assign nc       = NCW'(nc_full);
  assign pos_idx  = EW'(pos_c);
  assign is_final = ({2'b0, position} + 7'd1) >= ne;

  assign w_wr_en   = in_take && (s_tuser == FUNC_LOAD) &&
                     ({2'b0, weight_row} < 7'(MAX_ELECTRODES)) &&
                     ({3'b0, weight_column} < 9'(MAX_CHANNELS));
  assign w_wr_addr = WAW'({EW'(weight_row), CW'(weight_column)});

  assign cmd.start  = in_take && (s_tuser == FUNC_SAMPLE);
  assign cmd.first  = (position == '0);
  assign cmd.sample = sample_value;

  assign emit_start = (state == S_MAC) && mac_done && final_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      electrode_count <= ECOUNT_W'(1);
      channel_count   <= CCOUNT_W'(1);
      position        <= '0;
      final_pending   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ELECTRODE_COUNT: electrode_count <= cfg_data[ECOUNT_W-1:0];
          REG_CHANNEL_COUNT:   channel_count   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            final_pending <= is_final;
            position      <= is_final ? '0 : position + 1'b1;
            state         <= S_MAC;
          end
        end
        S_MAC: begin
          if (mac_done) begin
            state <= final_pending ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mvm_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (WDEPTH),
    .AW    (WAW)
  ) u_weight_ram (
    .clk     (clk),
    .wr_en   (w_wr_en),
    .wr_addr (w_wr_addr),
    .wr_data (weight_value),
    .rd_en   (w_rd_en),
    .rd_addr (w_rd_addr),
    .rd_data (w_rd_data)
  );

  mvm_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_CHANNELS),
    .AW    (CW)
  ) u_acc_ram (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (a_wr_addr),
    .wr_data (a_wr_data),
    .rd_en   (mac_a_rd_en || emit_a_rd_en),
    .rd_addr (mac_a_rd_en ? mac_a_rd_addr : emit_a_rd_addr),
    .rd_data (a_rd_data)
  );

  mvm_mac #(
    .MAX_ELECTRODES (MAX_ELECTRODES),
    .MAX_CHANNELS   (MAX_CHANNELS),
    .EW             (EW),
    .CW             (CW),
    .WAW            (WAW)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pos_idx   (pos_idx),
    .w_rd_en   (w_rd_en),
    .w_rd_addr (w_rd_addr),
    .w_rd_data (w_rd_data),
    .a_rd_en   (mac_a_rd_en),
    .a_rd_addr (mac_a_rd_addr),
    .a_rd_data (a_rd_data),
    .a_wr_en   (a_wr_en),
    .a_wr_addr (a_wr_addr),
    .a_wr_data (a_wr_data),
    .done      (mac_done)
  );

  mvm_emit #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CW           (CW),
    .NCW          (NCW)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (emit_start),
    .nc        (nc),
    .a_rd_en   (emit_a_rd_en),
    .a_rd_addr (emit_a_rd_addr),
    .a_rd_data (a_rd_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_index (out_index),
    .out_sum   (out_sum),
    .out_last  (m_tlast),
    .done      (emit_done)
  );

  assign m_tdata = {2'b00, out_sum, out_index};

endmodule

// ===== rtl/mvm_checker.sv =====
// ----------------------------------------------------------------------------
// mvm_checker
// Port-level checks of the matrix vector mixing block, bound to its top level.
// ----------------------------------------------------------------------------
module mvm_checker import mvm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast,
  input logic                  cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Output item changed while stalled.");

  a_no_input_during_output: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("Input accepted while a sum is pending.");

  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("Output item followed the last channel.");

  a_busy_between_sums: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready)
    else $error("Input accepted in the middle of a vector's output.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("Configuration port not ready.");

endmodule

bind matrix_vector_mix mvm_checker u_mvm_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .cfg_ready (cfg_ready)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for matrix_vector_mix. The first weight rows are loaded
// in full and every vector is kept within them, so no sample ever reads an
// unwritten weight. A short directed pass then covers extreme weights and
// samples, counts of zero, saturated counts and counts changed in the middle
// of a vector. Random phases with fresh counts follow. A scoreboard class
// mirrors the weight store and the accumulators, predicts every channel sum
// and checks each one as it leaves the block. Both stream sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import mvm_pkg::*;

  localparam int PAD_W = IN_DATA_W - ROW_W - COL_W - WEIGHT_W - SAMPLE_W;
  localparam int SETTLE_CYCLES = DEF_MAX_CHANNELS + 16;
  localparam int RANDOM_ITEMS = 90;
  localparam int LOADED_ROWS = 4;

  typedef struct {
    logic [INDEX_W-1:0]      channel;
    logic signed [SUM_W-1:0] total;
    logic                    last;
  } channel_sum_t;

  class channel_sum_board;
    logic [WEIGHT_W-1:0]     weights [DEF_MAX_ELECTRODES][DEF_MAX_CHANNELS];
    logic signed [SUM_W-1:0] acc [DEF_MAX_CHANNELS];
    int unsigned             position;
    int unsigned             electrodes_reg;
    int unsigned             channels_reg;
    channel_sum_t            pending_sums [$];
    int                      errors;
    int                      sums_checked;
    int                      loads;
    int                      samples;
    int                      vectors;

    function new();
      position = 0;
      electrodes_reg = 1;
      channels_reg = 1;
      errors = 0;
      sums_checked = 0;
      loads = 0;
      samples = 0;
      vectors = 0;
    endfunction

    function int unsigned clamp_count(int unsigned v, int unsigned top);
      if (v == 0) return 1;
      return (v > top) ? top : v;
    endfunction

    function void set_register(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_ELECTRODE_COUNT) begin
        electrodes_reg = data[ECOUNT_W-1:0];
      end else begin
        channels_reg = data[CCOUNT_W-1:0];
      end
    endfunction

    function int unsigned electrodes_to_go();
      int unsigned ne;
      ne = clamp_count(electrodes_reg, DEF_MAX_ELECTRODES);
      return (position < ne) ? ne - position : 1;
    endfunction

    // Applies one accepted item and queues the channel sums it releases.
    function void take_item(func_t f, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic [WEIGHT_W-1:0] wv, logic [SAMPLE_W-1:0] sv);
      logic signed [PROD_W-1:0] prod;
      logic signed [SUM_W-1:0]  ext;
      logic                     first;
      logic                     closing;
      int unsigned              nc;
      channel_sum_t             e;
      if (f == FUNC_LOAD) begin
        weights[row][col] = wv;
        loads++;
        return;
      end
      samples++;
      first = (position == 0);
      closing = (position + 1 >= clamp_count(electrodes_reg, DEF_MAX_ELECTRODES));
      for (int c = 0; c < DEF_MAX_CHANNELS; c++) begin
        prod = $signed(sv) * $signed(weights[position][c]);
        ext = prod;
        acc[c] = first ? ext : acc[c] + ext;
      end
      if (!closing) begin
        position = (position + 1) % DEF_MAX_ELECTRODES;
        return;
      end
      position = 0;
      vectors++;
      nc = clamp_count(channels_reg, DEF_MAX_CHANNELS);
      for (int c = 0; c < nc; c++) begin
        e.channel = INDEX_W'(c);
        e.total = acc[c];
        e.last = (c + 1 == nc);
        pending_sums.push_back(e);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_sum(logic [INDEX_W-1:0] channel, logic [SUM_W-1:0] total, logic last);
      channel_sum_t e;
      if (pending_sums.size() == 0) begin
        report($sformatf("unexpected sum for channel %0d", channel));
        return;
      end
      e = pending_sums.pop_front();
      sums_checked++;
      if (channel !== e.channel)
        report($sformatf("channel index %0d, expected %0d", channel, e.channel));
      if (total !== e.total)
        report($sformatf("channel %0d sum %0d, expected %0d",
                         e.channel, $signed(total), e.total));
      if (last !== e.last)
        report($sformatf("channel %0d last %0b, expected %0b", e.channel, last, e.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // weight_row, weight_column, weight_value, sample_value
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // func
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // channel_index, channel_sum
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  channel_sum_board sb = new();
  bit               steady = 1'b0;
  int               random_items = 0;

  matrix_vector_mix uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_sum(m_tdata[INDEX_W-1:0], m_tdata[INDEX_W +: SUM_W], m_tlast);
    end
  end

  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_item(func_t f, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic [WEIGHT_W-1:0] wv, logic [SAMPLE_W-1:0] sv);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser = f;
    s_tdata = {{PAD_W{1'b0}}, sv, wv, col, row};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.take_item(f, row, col, wv, sv);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_load(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic [WEIGHT_W-1:0] wv);
    send_item(FUNC_LOAD, row, col, wv, SAMPLE_W'($urandom));
  endtask

  task automatic send_sample(logic [SAMPLE_W-1:0] sv);
    send_item(FUNC_SAMPLE, ROW_W'($urandom), COL_W'($urandom), WEIGHT_W'($urandom), sv);
  endtask

  // The block may still be sweeping an item that released no sums.
  task automatic drain();
    while (sb.pending_sums.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    int unsigned n;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    steady = 1'b1;
    for (int r = 0; r < LOADED_ROWS; r++) begin
      for (int c = 0; c < DEF_MAX_CHANNELS; c++) begin
        send_load(ROW_W'(r), COL_W'(c), WEIGHT_W'($urandom));
      end
    end
    steady = 1'b0;

    write_register(REG_ELECTRODE_COUNT, 7'd2);
    write_register(REG_CHANNEL_COUNT, 7'd127);
    send_load(5'd0, 6'd0, 16'h8000);
    send_load(5'd0, 6'd63, 16'h7fff);
    send_load(5'd1, 6'd0, 16'h7fff);
    send_load(5'd1, 6'd63, 16'h8000);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h7fff);
    send_sample(16'h8000);

    drain();
    write_register(REG_ELECTRODE_COUNT, 7'd0);
    write_register(REG_CHANNEL_COUNT, 7'd0);
    send_sample(16'h7fff);
    send_sample(16'hffff);

    drain();
    write_register(REG_ELECTRODE_COUNT, 7'h43);
    write_register(REG_CHANNEL_COUNT, 7'd64);
    send_sample(SAMPLE_W'($urandom));
    send_load(5'd1, 6'd5, WEIGHT_W'($urandom));
    send_sample(SAMPLE_W'($urandom));
    send_sample(SAMPLE_W'($urandom));

    drain();
    write_register(REG_ELECTRODE_COUNT, 7'd4);
    write_register(REG_CHANNEL_COUNT, 7'd3);
    send_sample(SAMPLE_W'($urandom));
    send_sample(SAMPLE_W'($urandom));
    drain();
    write_register(REG_CHANNEL_COUNT, 7'd64);
    send_sample(SAMPLE_W'($urandom));
    drain();
    write_register(REG_ELECTRODE_COUNT, 7'd2);
    send_sample(SAMPLE_W'($urandom));

    while (random_items < RANDOM_ITEMS) begin
      drain();
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 9))
          0: write_register(REG_ELECTRODE_COUNT, 7'd0);
          1: write_register(REG_ELECTRODE_COUNT, 7'd32);
          2: write_register(REG_ELECTRODE_COUNT, CFG_DATA_W'($urandom_range(33, 127)));
          default: write_register(REG_ELECTRODE_COUNT, CFG_DATA_W'($urandom_range(1, 6)));
        endcase
      end
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 9))
          0: write_register(REG_CHANNEL_COUNT, 7'd0);
          1: write_register(REG_CHANNEL_COUNT, 7'd64);
          2: write_register(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(65, 127)));
          default: write_register(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(1, 64)));
        endcase
      end
      repeat ($urandom_range(1, 3)) begin
        n = sb.electrodes_to_go();
        if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
        // Vectors stay within the loaded weight rows.
        if ((sb.position + n > LOADED_ROWS) ||
            ((sb.position + n == LOADED_ROWS) && (n < sb.electrodes_to_go()))) begin
          drain();
          write_register(REG_ELECTRODE_COUNT, CFG_DATA_W'($urandom_range(0, LOADED_ROWS)));
          n = sb.electrodes_to_go();
        end
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) begin
            send_load(ROW_W'($urandom), COL_W'($urandom), WEIGHT_W'($urandom));
            random_items++;
          end
          send_sample(SAMPLE_W'($urandom));
          random_items++;
        end
      end
    end
    steady = 1'b0;

    while (sb.pending_sums.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Run covered %0d weight loads and %0d samples forming %0d vectors.",
             sb.loads, sb.samples, sb.vectors);
    $display("Checked %0d channel sums, %0d mismatches.", sb.sums_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
